/* design/egcd_pkg.sv */
// ============================================================================
// egcd_pkg
// Shared types, constants and the microcode store of the extended gcd unit.
// ============================================================================
package egcd_pkg;

    // Fixed field widths of the channels
    localparam int unsigned OPERAND_W = 31;
    localparam int unsigned COEF_W    = 32;

    // Step counter
    localparam int unsigned PC_W = 3;

    typedef logic [PC_W-1:0] pc_t;

    // Program addresses
    localparam pc_t STEP_LOAD     = 3'd0;
    localparam pc_t STEP_TEST     = 3'd1;
    localparam pc_t STEP_DIV_INIT = 3'd2;
    localparam pc_t STEP_DIV      = 3'd3;
    localparam pc_t STEP_UPDATE   = 3'd4;
    localparam pc_t STEP_EMIT     = 3'd5;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // Hold conditions: the step stays put until its channel is ready
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    // Branch conditions
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_RZERO,
        COND_CNT_NZ
    } cond_t;

    typedef struct packed {
        op_t   op;
        wait_t wait_kind;
        cond_t cond;
        pc_t   target;
    } cw_t;

    // Sequencer -> datapath
    typedef struct packed {
        op_t  op;
        logic exec;
    } ctrl_t;

    // Datapath -> sequencer
    typedef struct packed {
        logic r_zero;
        logic cnt_nz;
        logic out_free;
    } status_t;

    // Microprogram
    function automatic cw_t rom_word(input pc_t pc);
        cw_t cw;
        case (pc)
            STEP_LOAD:     cw = '{OP_LOAD,     WAIT_IN,   COND_NEXT,   STEP_LOAD};
            STEP_TEST:     cw = '{OP_NOP,      WAIT_NONE, COND_RZERO,  STEP_EMIT};
            STEP_DIV_INIT: cw = '{OP_DIV_INIT, WAIT_NONE, COND_NEXT,   STEP_LOAD};
            STEP_DIV:      cw = '{OP_DIV_STEP, WAIT_NONE, COND_CNT_NZ, STEP_DIV};
            STEP_UPDATE:   cw = '{OP_UPDATE,   WAIT_NONE, COND_ALWAYS, STEP_TEST};
            STEP_EMIT:     cw = '{OP_EMIT,     WAIT_OUT,  COND_ALWAYS, STEP_LOAD};
            default:       cw = '{OP_NOP,      WAIT_NONE, COND_ALWAYS, STEP_LOAD};
        endcase
        return cw;
    endfunction

endpackage

/* design/egcd_in_if.sv */
// ============================================================================
// egcd_in_if
// Operand channel: valid/ready handshake carrying one operand pair.
// ============================================================================
interface egcd_in_if;
    logic                                valid;
    logic                                ready;
    logic [egcd_pkg::OPERAND_W-1:0]      first_operand;
    logic [egcd_pkg::OPERAND_W-1:0]      second_operand;

    modport source (
        output valid,
        output first_operand,
        output second_operand,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_operand,
        input  second_operand,
        output ready
    );
endinterface

/* design/egcd_out_if.sv */
// ============================================================================
// egcd_out_if
// Result channel: valid/ready handshake carrying gcd, coefficient and flag.
// ============================================================================
interface egcd_out_if;
    logic                                valid;
    logic                                ready;
    logic [egcd_pkg::OPERAND_W-1:0]      gcd_value;
    logic signed [egcd_pkg::COEF_W-1:0]  coefficient;
    logic                                coprime;

    modport source (
        output valid,
        output gcd_value,
        output coefficient,
        output coprime,
        input  ready
    );

    modport sink (
        input  valid,
        input  gcd_value,
        input  coefficient,
        input  coprime,
        output ready
    );
endinterface

/* design/extended_gcd_unit.sv */
// ============================================================================
// extended_gcd_unit
// Extended Euclidean algorithm: gcd, Bezout coefficient of the second
// operand and a coprime flag, run by a small microcoded sequencer.
// ============================================================================
//
//  channel  | dir | fields                                  | handshake
//  ---------+-----+-----------------------------------------+-----------
//  in_ch    | in  | first_operand[30:0], second_operand[30:0]| valid/ready
//  out_ch   | out | gcd_value[30:0], coefficient[31:0] s,    | valid/ready
//           |     | coprime                                 |
//
//  Each item runs k Euclid steps, k <= ~46 at WIDTH = 31. Each step uses the
//  bit-serial divider: one quotient bit per cycle, WIDTH quotient bits per
//  step.
//  One item in flight; in_ch.ready is high only at the load step.
//  Reset clears the step counter and the result valid flag; no clearing pass.
//  A result held on out_ch does not stop the next item from being loaded and
//  computed; the unit waits only when a new result is ready and the old one
//  has not been taken.
//
// Microprogram (one control word per step):
//   LOAD      wait for an item, set r_prev/r_cur, t_prev = 0, t_cur = 1
//   TEST      r_cur == 0 -> EMIT
//   DIV_INIT  clear remainder/accumulator, start bit counter
//   DIV       restoring divide bit, acc = 2*acc + q_bit*t_cur; loop WIDTH times
//   UPDATE    rotate remainders and t = t_prev - q*t_cur; back to TEST
//   EMIT      wait for a free result register, write it, back to LOAD
//
// The coefficient is only ever needed modulo 2^32, so t and q*t are kept in
// 32 bits throughout.
// ============================================================================
module extended_gcd_unit #(
    parameter int unsigned WIDTH = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    egcd_in_if.sink     in_ch,
    egcd_out_if.source  out_ch
);

    egcd_pkg::ctrl_t   ctrl;
    egcd_pkg::status_t status;

    egcd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ch.ready)
    );

    egcd_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .first_operand  (in_ch.first_operand),
        .second_operand (in_ch.second_operand),
        .out_ready      (out_ch.ready),
        .status         (status),
        .out_valid      (out_ch.valid),
        .gcd_value      (out_ch.gcd_value),
        .coefficient    (out_ch.coefficient),
        .coprime        (out_ch.coprime)
    );

endmodule

/* design/egcd_seq.sv */
// ============================================================================
// egcd_seq
// Microcode sequencer: step counter, control store fetch, holds and jumps.
// ============================================================================
module egcd_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  egcd_pkg::status_t   status,
    output egcd_pkg::ctrl_t     ctrl,
    output logic                in_ready
);

    egcd_pkg::pc_t pc_reg;
    egcd_pkg::pc_t pc_next;
    egcd_pkg::cw_t cw;
    logic          stall;
    logic          taken;

    always_comb
    begin
        cw    = egcd_pkg::rom_word(pc_reg);
        stall = ((cw.wait_kind == egcd_pkg::WAIT_IN)  && !in_valid) ||
                ((cw.wait_kind == egcd_pkg::WAIT_OUT) && !status.out_free);
        case (cw.cond)
            egcd_pkg::COND_NEXT:   taken = 1'b0;
            egcd_pkg::COND_ALWAYS: taken = 1'b1;
            egcd_pkg::COND_RZERO:  taken = status.r_zero;
            egcd_pkg::COND_CNT_NZ: taken = status.cnt_nz;
            default:               taken = 1'b0;
        endcase
        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + egcd_pkg::pc_t'(1);
        end
    end

    assign ctrl.op   = cw.op;
    assign ctrl.exec = !stall;
    assign in_ready  = (cw.wait_kind == egcd_pkg::WAIT_IN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= egcd_pkg::STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* design/egcd_dp.sv */
// ============================================================================
// egcd_dp
// Euclid datapath: remainder/coefficient registers, bit-serial restoring
// divider with Horner accumulation of quotient * t, and the result register.
// ============================================================================
module egcd_dp #(
    parameter int unsigned WIDTH = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  egcd_pkg::ctrl_t                     ctrl,
    input  logic [egcd_pkg::OPERAND_W-1:0]      first_operand,
    input  logic [egcd_pkg::OPERAND_W-1:0]      second_operand,
    input  logic                                out_ready,
    output egcd_pkg::status_t                   status,
    output logic                                out_valid,
    output logic [egcd_pkg::OPERAND_W-1:0]      gcd_value,
    output logic signed [egcd_pkg::COEF_W-1:0]  coefficient,
    output logic                                coprime
);

    localparam int unsigned CNT_W = $clog2(WIDTH);
    localparam int unsigned C_W   = egcd_pkg::COEF_W;
    localparam int unsigned EXT_W = 64;

    logic [WIDTH-1:0] r_prev_reg, r_prev_next;
    logic [WIDTH-1:0] r_cur_reg,  r_cur_next;
    logic [C_W-1:0]   t_prev_reg, t_prev_next;
    logic [C_W-1:0]   t_cur_reg,  t_cur_next;
    logic [WIDTH-1:0] rem_reg,    rem_next;
    logic [WIDTH-1:0] dvd_reg,    dvd_next;
    logic [C_W-1:0]   acc_reg,    acc_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [egcd_pkg::OPERAND_W-1:0]  gcd_reg,       gcd_next;
    logic [C_W-1:0]                  coef_reg,      coef_next;
    logic                            coprime_reg,   coprime_next;

    logic [EXT_W-2:0] m_ext;
    logic [EXT_W-2:0] v_ext;
    logic [EXT_W-1:0] g_ext;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;
    logic             qbit;
    logic             go;

    // Operands truncated/extended to the datapath width
    assign m_ext = (EXT_W-1)'(first_operand);
    assign v_ext = (EXT_W-1)'(second_operand);
    assign g_ext = EXT_W'(r_prev_reg);

    // One restoring division step
    assign shifted = {rem_reg, dvd_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, r_cur_reg};
    assign qbit    = !trial[WIDTH];

    assign go = ctrl.exec;

    always_comb
    begin
        r_prev_next    = r_prev_reg;
        r_cur_next     = r_cur_reg;
        t_prev_next    = t_prev_reg;
        t_cur_next     = t_cur_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        gcd_next       = gcd_reg;
        coef_next      = coef_reg;
        coprime_next   = coprime_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (go)
        begin
            case (ctrl.op)
                egcd_pkg::OP_LOAD:
                begin
                    r_prev_next = m_ext[WIDTH-1:0];
                    r_cur_next  = v_ext[WIDTH-1:0];
                    t_prev_next = '0;
                    t_cur_next  = C_W'(1);
                end
                egcd_pkg::OP_DIV_INIT:
                begin
                    rem_next = '0;
                    dvd_next = r_prev_reg;
                    acc_next = '0;
                    cnt_next = CNT_W'(WIDTH - 1);
                end
                egcd_pkg::OP_DIV_STEP:
                begin
                    rem_next = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
                    dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
                    // acc = 2*acc + qbit*t_cur, modulo 2^32
                    acc_next = {acc_reg[C_W-2:0], 1'b0} + (qbit ? t_cur_reg : '0);
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                egcd_pkg::OP_UPDATE:
                begin
                    r_prev_next = r_cur_reg;
                    r_cur_next  = rem_reg;
                    t_prev_next = t_cur_reg;
                    t_cur_next  = t_prev_reg - acc_reg;
                end
                egcd_pkg::OP_EMIT:
                begin
                    gcd_next       = g_ext[egcd_pkg::OPERAND_W-1:0];
                    coef_next      = t_prev_reg;
                    coprime_next   = (r_prev_reg == WIDTH'(1));
                    out_valid_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.r_zero   = (r_cur_reg == '0);
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign gcd_value   = gcd_reg;
    assign coefficient = coef_reg;
    assign coprime     = coprime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_prev_reg  <= r_prev_next;
        r_cur_reg   <= r_cur_next;
        t_prev_reg  <= t_prev_next;
        t_cur_reg   <= t_cur_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        acc_reg     <= acc_next;
        gcd_reg     <= gcd_next;
        coef_reg    <= coef_next;
        coprime_reg <= coprime_next;
    end

endmodule
